// ===== hw/rtl/line_word_tokenizer_macros.svh =====
// assertion macros shared by the tokenizer modules
`ifndef LINE_WORD_TOKENIZER_MACROS_SVH
`define LINE_WORD_TOKENIZER_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, held off during reset
`define LWT_ASSERT_IMPLY(name, clk_s, rst_s, ante, cons) \
	name: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
		else $error("tokenizer check failed");

// next-cycle implication, held off during reset
`define LWT_ASSERT_NEXT(name, clk_s, rst_s, ante, cons) \
	name: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
		else $error("tokenizer check failed");

`else

`define LWT_ASSERT_IMPLY(name, clk_s, rst_s, ante, cons)
`define LWT_ASSERT_NEXT(name, clk_s, rst_s, ante, cons)

`endif

`endif

// ===== hw/rtl/lwt_pkg.sv =====
package lwt_pkg;

	// result kinds
	typedef enum logic [1:0] {
		KIND_WORD = 2'd0,
		KIND_LINE = 2'd1,
		KIND_END  = 2'd2,
		KIND_ERR  = 2'd3
	} kind_t;

	// error codes
	typedef enum logic [1:0] {
		ERR_BAD_ESCAPE  = 2'd0,
		ERR_BAD_OCTAL   = 2'd1,
		ERR_STRAY_QUOTE = 2'd2,
		ERR_UNTERM      = 2'd3
	} err_t;

	// one result beat without its last flag
	typedef struct packed {
		kind_t      kind;
		logic [7:0] word_byte;
		logic       word_start;
		logic [7:0] word_count;
		err_t       error_code;
	} res_t;

	// results of one input beat, one or two of them
	typedef struct packed {
		res_t first;
		res_t second;
		logic two;
	} entry_t;

endpackage

// ===== hw/rtl/lwt_in_if.sv =====
interface lwt_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_byte;
	logic       end_of_input;

	modport source (output valid, output char_byte, output end_of_input, input ready);
	modport sink (input valid, input char_byte, input end_of_input, output ready);
endinterface

// ===== hw/rtl/lwt_out_if.sv =====
interface lwt_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] word_byte;
	logic       word_start;
	logic [7:0] word_count;
	logic [1:0] error_code;
	logic       last_result;

	modport source (
		output valid, output kind, output word_byte, output word_start,
		output word_count, output error_code, output last_result, input ready
	);
	modport sink (
		input valid, input kind, input word_byte, input word_start,
		input word_count, input error_code, input last_result, output ready
	);
endinterface

// ===== hw/rtl/lwt_front.sv =====
`include "line_word_tokenizer_macros.svh"

module lwt_front
	import lwt_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	lwt_in_if.sink text,
	input  logic   room,
	output logic   push,
	output entry_t entry
);

	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_SEVEN  = 8'h37;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_LOW_N  = 8'h6E;
	localparam logic [7:0] MAX_WORDS = 8'hFF;

	typedef enum logic [3:0] {
		SCAN_HUNT    = 4'b0001,
		SCAN_COMMENT = 4'b0010,
		SCAN_WORD    = 4'b0100,
		SCAN_STRING  = 4'b1000
	} scan_t;

	typedef enum logic [3:0] {
		ESC_NONE  = 4'b0001,
		ESC_SLASH = 4'b0010,
		ESC_ONE   = 4'b0100,
		ESC_TWO   = 4'b1000
	} esc_t;

	scan_t      scan_q, scan_d;
	esc_t       esc_q, esc_d;
	logic [8:0] oct_q, oct_d;
	logic [7:0] words_q, words_d;
	logic       pend_q, pend_d;
	logic       hold_q, hold_d;

	logic       accept, eof;
	logic [7:0] c;
	logic       is_nl, is_blank, is_quote, is_hash, is_bslash, is_low_n, is_digit;
	logic       is_simple, end_line;
	logic [2:0] digit;
	logic [8:0] oct_sum;
	logic [7:0] words_inc;

	logic       line_end, do_fail, do_put, do_clear;
	err_t       fail_code;
	logic [7:0] put_val;
	logic       put_start;
	res_t       r0, r1;
	logic       any_res, two_res;

	assign accept     = text.valid & room;
	assign text.ready = room;
	assign eof        = text.end_of_input;
	assign c          = text.char_byte;

	// character classes, none of them match at end of input except end_line, which does
	assign is_nl     = !eof && (c == CH_NL);
	assign is_blank  = !eof && ((c == CH_SPACE) || (c == CH_TAB));
	assign is_quote  = !eof && (c == CH_QUOTE);
	assign is_hash   = !eof && (c == CH_HASH);
	assign is_bslash = !eof && (c == CH_BSLASH);
	assign is_low_n  = !eof && (c == CH_LOW_N);
	assign is_digit  = !eof && (c >= CH_ZERO) && (c <= CH_SEVEN);
	assign is_simple = is_quote || is_hash || is_bslash || (!eof && (c == CH_SPACE));
	assign end_line  = eof || is_nl;
	assign digit     = c[2:0];

	// octal accumulate, second digit weighs eight, third weighs one
	assign oct_sum   = oct_q + ((esc_q == ESC_ONE) ? {3'b000, digit, 3'b000}
	                                               : {6'b000000, digit});
	assign words_inc = (words_q == MAX_WORDS) ? MAX_WORDS : words_q + 8'd1;

	// classify the beat
	always_comb begin
		scan_d    = scan_q;
		esc_d     = esc_q;
		oct_d     = oct_q;
		words_d   = words_q;
		pend_d    = pend_q;
		hold_d    = hold_q;
		line_end  = 1'b0;
		do_fail   = 1'b0;
		do_put    = 1'b0;
		do_clear  = 1'b0;
		fail_code = ERR_BAD_ESCAPE;
		put_val   = c;
		put_start = pend_q;

		if (hold_q) begin
			do_clear = eof;
		end else if (esc_q == ESC_SLASH && is_nl) begin
			// line continuation
			esc_d = ESC_NONE;
		end else begin
			unique case (scan_q) inside
				SCAN_COMMENT: begin
					line_end = end_line;
				end
				SCAN_HUNT: begin
					if (end_line) begin
						line_end = 1'b1;
					end else if (is_blank) begin
						scan_d = SCAN_HUNT;
					end else if (is_quote) begin
						words_d = words_inc;
						pend_d  = 1'b1;
						scan_d  = SCAN_STRING;
					end else if (is_hash) begin
						scan_d = SCAN_COMMENT;
					end else begin
						words_d = words_inc;
						pend_d  = 1'b1;
						scan_d  = SCAN_WORD;
						if (is_bslash) begin
							esc_d = ESC_SLASH;
						end else begin
							do_put    = 1'b1;
							put_start = 1'b1;
						end
					end
				end
				SCAN_WORD, SCAN_STRING: begin
					if (esc_q == ESC_SLASH) begin
						if (is_simple) begin
							do_put = 1'b1;
							esc_d  = ESC_NONE;
						end else if (is_low_n) begin
							do_put  = 1'b1;
							put_val = CH_NL;
							esc_d   = ESC_NONE;
						end else if (is_digit) begin
							oct_d = {digit, 6'b000000};
							esc_d = ESC_ONE;
						end else begin
							do_fail   = 1'b1;
							fail_code = ERR_BAD_ESCAPE;
						end
					end else if (esc_q != ESC_NONE) begin
						if (!is_digit) begin
							do_fail   = 1'b1;
							fail_code = ERR_BAD_OCTAL;
						end else if (esc_q == ESC_ONE) begin
							oct_d = oct_sum;
							esc_d = ESC_TWO;
						end else begin
							oct_d   = oct_sum;
							esc_d   = ESC_NONE;
							do_put  = 1'b1;
							put_val = oct_sum[7:0];
						end
					end else if (scan_q == SCAN_WORD) begin
						if (is_blank) begin
							scan_d = SCAN_HUNT;
						end else if (end_line) begin
							line_end = 1'b1;
						end else if (is_bslash) begin
							esc_d = ESC_SLASH;
						end else if (is_quote) begin
							do_fail   = 1'b1;
							fail_code = ERR_STRAY_QUOTE;
						end else if (is_hash) begin
							scan_d = SCAN_COMMENT;
						end else begin
							do_put = 1'b1;
						end
					end else begin
						if (is_bslash) begin
							esc_d = ESC_SLASH;
						end else if (end_line) begin
							do_fail   = 1'b1;
							fail_code = ERR_UNTERM;
						end else if (is_quote) begin
							scan_d = SCAN_HUNT;
						end else begin
							do_put = 1'b1;
						end
					end
				end
				default: begin
					scan_d = SCAN_HUNT;
				end
			endcase
		end

		// build the results
		r0      = '0;
		r1      = '0;
		any_res = 1'b0;
		two_res = 1'b0;

		if (do_put) begin
			r0.kind       = KIND_WORD;
			r0.word_byte  = put_val;
			r0.word_start = put_start;
			any_res       = 1'b1;
			pend_d        = 1'b0;
		end

		if (do_fail) begin
			r0.kind       = KIND_ERR;
			r0.error_code = fail_code;
			any_res       = 1'b1;
			if (eof) begin
				r1.kind  = KIND_END;
				two_res  = 1'b1;
				do_clear = 1'b1;
			end else begin
				hold_d = 1'b1;
			end
		end

		if (line_end) begin
			scan_d = SCAN_HUNT;
			if (words_q != '0) begin
				r0.kind       = KIND_LINE;
				r0.word_count = words_q;
				any_res       = 1'b1;
			end
			if (eof) begin
				do_clear = 1'b1;
				if (words_q != '0) begin
					r1.kind = KIND_END;
					two_res = 1'b1;
				end
			end else begin
				words_d = '0;
				pend_d  = 1'b0;
			end
		end

		if (do_clear) begin
			if (!two_res) begin
				r0      = '0;
				r0.kind = KIND_END;
				any_res = 1'b1;
			end
			scan_d  = SCAN_HUNT;
			esc_d   = ESC_NONE;
			oct_d   = '0;
			words_d = '0;
			pend_d  = 1'b0;
			hold_d  = 1'b0;
		end
	end

	assign push         = accept && any_res;
	assign entry.first  = r0;
	assign entry.second = r1;
	assign entry.two    = two_res;

	// scanner state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q  <= SCAN_HUNT;
			esc_q   <= ESC_NONE;
			oct_q   <= '0;
			words_q <= '0;
			pend_q  <= 1'b0;
			hold_q  <= 1'b0;
		end else if (accept) begin
			scan_q  <= scan_d;
			esc_q   <= esc_d;
			oct_q   <= oct_d;
			words_q <= words_d;
			pend_q  <= pend_d;
			hold_q  <= hold_d;
		end
	end

	// an escape is only ever open inside a word or a string
	`LWT_ASSERT_IMPLY(a_esc_in_token, clk, arst_n, esc_q != ESC_NONE, scan_q == SCAN_WORD || scan_q == SCAN_STRING)
	// after an error only end of input makes a result
	`LWT_ASSERT_IMPLY(a_hold_quiet, clk, arst_n, hold_q && accept && !eof, !push)

endmodule

// ===== hw/rtl/lwt_queue.sv =====
`include "line_word_tokenizer_macros.svh"

module lwt_queue
	import lwt_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_entry,
	output logic   room,
	input  logic   pop,
	output entry_t head,
	output logic   nonempty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	entry_t           entries_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign room     = (count_q != FULL_CNT);
	assign nonempty = (count_q != '0);
	assign head     = entries_q[rd_ptr_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_entry;
		end
	end

	`LWT_ASSERT_IMPLY(a_no_pop_empty, clk, arst_n, pop, count_q != '0)
	`LWT_ASSERT_IMPLY(a_no_push_full, clk, arst_n, push, count_q != FULL_CNT)
	`LWT_ASSERT_NEXT(a_fill_up, clk, arst_n, push && !pop, count_q == $past(count_q) + 1'b1)

endmodule

// ===== hw/rtl/lwt_back.sv =====
`include "line_word_tokenizer_macros.svh"

module lwt_back
	import lwt_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  entry_t    head,
	input  logic      nonempty,
	output logic      pop,
	lwt_out_if.source tokens
);

	logic out_valid_q;
	res_t out_res_q;
	logic out_last_q;
	logic sel_q;

	logic load;
	res_t cur;
	logic cur_last;

	// pick the next beat of the head entry
	assign load     = !out_valid_q || tokens.ready;
	assign cur      = sel_q ? head.second : head.first;
	assign cur_last = !head.two || sel_q;
	assign pop      = load && nonempty && cur_last;

	// output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			sel_q       <= 1'b0;
		end else if (load) begin
			out_valid_q <= nonempty;
			if (nonempty) begin
				sel_q <= !cur_last;
			end
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (load && nonempty) begin
			out_res_q  <= cur;
			out_last_q <= cur_last;
		end
	end

	assign tokens.valid       = out_valid_q;
	assign tokens.kind        = out_res_q.kind;
	assign tokens.word_byte   = out_res_q.word_byte;
	assign tokens.word_start  = out_res_q.word_start;
	assign tokens.word_count  = out_res_q.word_count;
	assign tokens.error_code  = out_res_q.error_code;
	assign tokens.last_result = out_last_q;

	// the second half of a pair is only pending while its entry is at the head
	`LWT_ASSERT_IMPLY(a_second_pending, clk, arst_n, sel_q, nonempty && head.two)

endmodule

// ===== hw/rtl/line_word_tokenizer.sv =====
// path: an accepted input beat is written into the queue, then loaded into the output register on tokens
// throughput: one input beat per cycle while the queue has room; each result is its own output beat, so a beat
// with two results (line end plus end of input, error plus end of input) holds the output side longer,
// absorbed by the QUEUE_DEPTH entry queue between front and back
// reset: arst_n clears the scanner state, the queue and the output register at once
module line_word_tokenizer
	import lwt_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	lwt_in_if.sink    text,
	lwt_out_if.source tokens
);

	logic   room;
	logic   push;
	entry_t push_entry;
	logic   pop;
	entry_t head;
	logic   nonempty;

	// scanner and classifier
	lwt_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text),
		.room   (room),
		.push   (push),
		.entry  (push_entry)
	);

	// decoupling queue
	lwt_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.room       (room),
		.pop        (pop),
		.head       (head),
		.nonempty   (nonempty)
	);

	// result serializer
	lwt_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.nonempty (nonempty),
		.pop      (pop),
		.tokens   (tokens)
	);

endmodule
